// ===== rtl/lav_pkg.sv =====
`default_nettype none

package lav_pkg;

    localparam int AXIS_FRAC = 30;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;
    // mag, max, lead-one, scale, square, sum, sqrt steps, divide setup, divide steps, output
    localparam int NORM_LAT  = 8 + SQ_STEPS + DIV_STEPS;
    localparam int CROSS_LAT = 2;
    localparam int DOT_LAT   = 3;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    typedef logic [2:0][31:0] vec32_t;
    typedef logic [2:0][62:0] vec63_t;
    typedef logic [2:0][30:0] vec31_t;
    typedef logic [2:0][63:0] vec64_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } sq_state_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] lq;
    } div_state_t;

    typedef div_state_t [2:0] div_vec_t;

    // one radix-4 digit of the integer square root
    function automatic sq_state_t sq_step(sq_state_t s, logic [1:0] b);
        sq_state_t r;
        logic [34:0] rn;
        logic [34:0] tr;
        rn = {s.rem[32:0], b};
        tr = {1'b0, s.root, 2'b01};
        if (rn >= tr)
        begin
            r.rem  = 34'(rn - tr);
            r.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = rn[33:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of restoring division
    function automatic div_state_t div_step(div_state_t s, logic [31:0] d);
        div_state_t r;
        logic [32:0] r2;
        r2 = {s.rem, s.lq[31]};
        if (r2 >= {1'b0, d})
        begin
            r.rem = 32'(r2 - {1'b0, d});
            r.lq  = {s.lq[30:0], 1'b1};
        end
        else
        begin
            r.rem = r2[31:0];
            r.lq  = {s.lq[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lav_norm.sv =====
`default_nettype none

module lav_norm #(
    parameter int SIDE_W = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_valid,
    input  wire lav_pkg::vec64_t       in_vec,
    input  wire logic [SIDE_W-1:0]     in_side,
    output logic                       out_valid,
    output lav_pkg::vec32_t            out_vec,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int LAT    = lav_pkg::NORM_LAT;
    localparam int ST_SQ0 = 7;
    localparam int ST_SQ1 = ST_SQ0 + lav_pkg::SQ_STEPS - 1;
    localparam int ST_DV0 = ST_SQ1 + 1;
    localparam int ST_DV1 = ST_DV0 + lav_pkg::DIV_STEPS;

    logic [LAT:1]        v_reg;
    logic [SIDE_W-1:0]   side_reg [1:LAT];
    logic [2:0]          neg_reg [1:LAT-1];
    lav_pkg::vec63_t     mag_reg [1:3];
    logic [62:0]         mx_reg;
    logic [5:0]          rsh_reg;
    logic [4:0]          lsh_reg;
    logic                zero_reg [3:LAT-1];
    lav_pkg::vec31_t     m_reg [4:ST_DV0-1];
    logic [2:0][61:0]    sqm_reg;
    logic [63:0]         sum_reg;
    lav_pkg::sq_state_t  sqs_reg [ST_SQ0:ST_SQ1];
    logic [63:0]         rad_reg [ST_SQ0:ST_SQ1-1];
    lav_pkg::div_vec_t   dvs_reg [ST_DV0:ST_DV1];
    logic [31:0]         len_reg [ST_DV0:ST_DV1-1];
    lav_pkg::vec32_t     out_reg;

    logic [62:0]         mx_next;
    logic [5:0]          pos;
    logic [5:0]          rsh_next;
    logic [4:0]          lsh_next;
    logic                zero_next;

    always_comb
    begin
        mx_next = mag_reg[1][0];
        if (mag_reg[1][1] > mx_next)
        begin
            mx_next = mag_reg[1][1];
        end
        if (mag_reg[1][2] > mx_next)
        begin
            mx_next = mag_reg[1][2];
        end
    end

    // leading one of the largest magnitude picks the scale into [2^30, 2^31)
    always_comb
    begin
        pos = '0;
        for (int k = 0; k < 63; k++)
        begin
            if (mx_reg[k])
            begin
                pos = 6'(k);
            end
        end
        zero_next = (mx_reg == '0);
        rsh_next  = (pos >= 6'd30) ? 6'(pos - 6'd30) : 6'd0;
        lsh_next  = (pos < 6'd30) ? 5'(6'd30 - pos) : 5'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAT-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1] <= in_side;
            for (int k = 2; k <= LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[1][i] <= in_vec[i][63];
                mag_reg[1][i] <= in_vec[i][63] ? 63'(-in_vec[i]) : in_vec[i][62:0];
            end
            for (int k = 2; k <= LAT - 1; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
            end
            mag_reg[2] <= mag_reg[1];
            mag_reg[3] <= mag_reg[2];
            mx_reg     <= mx_next;

            rsh_reg     <= rsh_next;
            lsh_reg     <= lsh_next;
            zero_reg[3] <= zero_next;
            for (int k = 4; k <= LAT - 1; k++)
            begin
                zero_reg[k] <= zero_reg[k-1];
            end

            for (int i = 0; i < 3; i++)
            begin
                m_reg[4][i] <= 31'((mag_reg[3][i] >> rsh_reg) << lsh_reg);
            end
            for (int k = 5; k <= ST_DV0 - 1; k++)
            begin
                m_reg[k] <= m_reg[k-1];
            end

            for (int i = 0; i < 3; i++)
            begin
                sqm_reg[i] <= 62'(m_reg[4][i]) * 62'(m_reg[4][i]);
            end
            sum_reg <= 64'(sqm_reg[0]) + 64'(sqm_reg[1]) + 64'(sqm_reg[2]);

            sqs_reg[ST_SQ0] <= lav_pkg::sq_step('0, sum_reg[63:62]);
            rad_reg[ST_SQ0] <= sum_reg << 2;
            for (int k = ST_SQ0 + 1; k <= ST_SQ1; k++)
            begin
                sqs_reg[k] <= lav_pkg::sq_step(sqs_reg[k-1], rad_reg[k-1][63:62]);
            end
            for (int k = ST_SQ0 + 1; k <= ST_SQ1 - 1; k++)
            begin
                rad_reg[k] <= rad_reg[k-1] << 2;
            end

            // numerator m * 2^30 + len / 2, upper half preloads the remainder
            for (int i = 0; i < 3; i++)
            begin
                dvs_reg[ST_DV0][i] <= {3'b000, m_reg[ST_DV0-1][i], 30'd0}
                                      + {33'd0, sqs_reg[ST_SQ1].root[31:1]};
            end
            len_reg[ST_DV0] <= sqs_reg[ST_SQ1].root;
            for (int k = ST_DV0 + 1; k <= ST_DV1 - 1; k++)
            begin
                len_reg[k] <= len_reg[k-1];
            end
            for (int k = ST_DV0 + 1; k <= ST_DV1; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dvs_reg[k][i] <= lav_pkg::div_step(dvs_reg[k-1][i], len_reg[k-1]);
                end
            end

            for (int i = 0; i < 3; i++)
            begin
                if (zero_reg[LAT-1])
                begin
                    out_reg[i] <= '0;
                end
                else if (dvs_reg[ST_DV1][i].lq > lav_pkg::ONE_Q30)
                begin
                    out_reg[i] <= neg_reg[LAT-1][i] ? 32'(-lav_pkg::ONE_Q30)
                                                    : lav_pkg::ONE_Q30;
                end
                else
                begin
                    out_reg[i] <= neg_reg[LAT-1][i] ? 32'(-dvs_reg[ST_DV1][i].lq)
                                                    : dvs_reg[ST_DV1][i].lq;
                end
            end
        end
    end

    assign out_valid = v_reg[LAT];
    assign out_vec   = out_reg;
    assign out_side  = side_reg[LAT];

endmodule

`default_nettype wire

// ===== rtl/lav_cross.sv =====
`default_nettype none

module lav_cross #(
    parameter int SIDE_W = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_valid,
    input  wire lav_pkg::vec32_t       a,
    input  wire lav_pkg::vec32_t       b,
    input  wire logic [SIDE_W-1:0]     in_side,
    output logic                       out_valid,
    output lav_pkg::vec64_t            out_vec,
    output logic [SIDE_W-1:0]          out_side
);

    logic [1:0]          v_reg;
    logic [5:0][63:0]    p_reg;
    lav_pkg::vec64_t     c_reg;
    logic [SIDE_W-1:0]   side_reg [1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= $signed(a[1]) * $signed(b[2]);
            p_reg[1] <= $signed(a[2]) * $signed(b[1]);
            p_reg[2] <= $signed(a[2]) * $signed(b[0]);
            p_reg[3] <= $signed(a[0]) * $signed(b[2]);
            p_reg[4] <= $signed(a[0]) * $signed(b[1]);
            p_reg[5] <= $signed(a[1]) * $signed(b[0]);
            c_reg[0] <= p_reg[0] - p_reg[1];
            c_reg[1] <= p_reg[2] - p_reg[3];
            c_reg[2] <= p_reg[4] - p_reg[5];
            side_reg[1] <= in_side;
            side_reg[2] <= side_reg[1];
        end
    end

    assign out_valid = v_reg[1];
    assign out_vec   = c_reg;
    assign out_side  = side_reg[2];

endmodule

`default_nettype wire

// ===== rtl/look_at_view_matrix.sv =====
`default_nettype none

// Right-handed look-at view transform. Each request carries eye, target and up
// (signed Q16.16) and yields the right, up and back axes in Q1.30 plus the three
// translations -(axis . eye) in Q16.16, rounded half away from zero and saturated.
// A new request is taken every cycle unless the output stalls. A stall at the
// output freezes the whole pipeline. Three normalizers, each a 32-step square root
// followed by 32-step dividers, one step per stage, are chained through cross
// products. A zero-length axis comes out as zeros, as do the axes derived from it.
module look_at_view_matrix (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [31:0]  eye_x,
    input  wire logic signed [31:0]  eye_y,
    input  wire logic signed [31:0]  eye_z,
    input  wire logic signed [31:0]  target_x,
    input  wire logic signed [31:0]  target_y,
    input  wire logic signed [31:0]  target_z,
    input  wire logic signed [31:0]  up_x,
    input  wire logic signed [31:0]  up_y,
    input  wire logic signed [31:0]  up_z,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [31:0]       right_x,
    output logic signed [31:0]       right_y,
    output logic signed [31:0]       right_z,
    output logic signed [31:0]       right_shift,
    output logic signed [31:0]       upward_x,
    output logic signed [31:0]       upward_y,
    output logic signed [31:0]       upward_z,
    output logic signed [31:0]       upward_shift,
    output logic signed [31:0]       back_x,
    output logic signed [31:0]       back_y,
    output logic signed [31:0]       back_z,
    output logic signed [31:0]       back_shift
);

    logic                adv;
    logic                v1_reg;
    logic [2:0][32:0]    d_reg;
    lav_pkg::vec32_t     eye_reg;
    lav_pkg::vec32_t     up_reg;
    lav_pkg::vec64_t     n1_in;

    logic                n1_valid;
    lav_pkg::vec32_t     bk1;
    logic [191:0]        n1_side;
    logic                c1_valid;
    lav_pkg::vec64_t     c1_vec;
    logic [191:0]        c1_side;
    logic                n2_valid;
    lav_pkg::vec32_t     rt2;
    logic [191:0]        n2_side;
    logic                c2_valid;
    lav_pkg::vec64_t     c2_vec;
    logic [287:0]        c2_side;
    logic                n3_valid;
    lav_pkg::vec32_t     uw3;
    logic [287:0]        n3_side;

    lav_pkg::vec32_t     eye3;
    lav_pkg::vec32_t     ax_in [0:2];

    logic [2:0]          dv_reg;
    logic [2:0][2:0][63:0] prod_reg;
    logic [2:0][63:0]    dot_reg;
    lav_pkg::vec32_t     ax1_reg [0:2];
    lav_pkg::vec32_t     ax2_reg [0:2];
    lav_pkg::vec32_t     ax_reg  [0:2];
    logic [2:0][31:0]    sh_reg;

    function automatic logic [31:0] shift_of(logic [63:0] d);
        logic [63:0] m;
        logic [63:0] t;
        logic [33:0] r;
        m = d[63] ? 64'(-d) : d;
        t = m + 64'h2000_0000;
        r = t[63:30];
        if (d[63])
        begin
            return (r > 34'(lav_pkg::POS_MAX)) ? lav_pkg::POS_MAX : r[31:0];
        end
        else
        begin
            return (r > 34'(lav_pkg::NEG_MAX)) ? lav_pkg::NEG_MAX : 32'(-r);
        end
    endfunction

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            dv_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            dv_reg <= {dv_reg[1:0], n3_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg[0] <= 33'($signed(eye_x)) - 33'($signed(target_x));
            d_reg[1] <= 33'($signed(eye_y)) - 33'($signed(target_y));
            d_reg[2] <= 33'($signed(eye_z)) - 33'($signed(target_z));
            eye_reg  <= {eye_z, eye_y, eye_x};
            up_reg   <= {up_z, up_y, up_x};
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_in[i] = {{31{d_reg[i][32]}}, d_reg[i]};
        end
    end

    lav_norm #(.SIDE_W(192)) u_norm_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v1_reg),
        .in_vec    (n1_in),
        .in_side   ({eye_reg, up_reg}),
        .out_valid (n1_valid),
        .out_vec   (bk1),
        .out_side  (n1_side)
    );

    // up x back
    lav_cross #(.SIDE_W(192)) u_cross_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (n1_valid),
        .a         (n1_side[95:0]),
        .b         (bk1),
        .in_side   ({n1_side[191:96], bk1}),
        .out_valid (c1_valid),
        .out_vec   (c1_vec),
        .out_side  (c1_side)
    );

    lav_norm #(.SIDE_W(192)) u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c1_valid),
        .in_vec    (c1_vec),
        .in_side   (c1_side),
        .out_valid (n2_valid),
        .out_vec   (rt2),
        .out_side  (n2_side)
    );

    // back x right
    lav_cross #(.SIDE_W(288)) u_cross_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (n2_valid),
        .a         (n2_side[95:0]),
        .b         (rt2),
        .in_side   ({n2_side, rt2}),
        .out_valid (c2_valid),
        .out_vec   (c2_vec),
        .out_side  (c2_side)
    );

    lav_norm #(.SIDE_W(288)) u_norm_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (c2_valid),
        .in_vec    (c2_vec),
        .in_side   (c2_side),
        .out_valid (n3_valid),
        .out_vec   (uw3),
        .out_side  (n3_side)
    );

    assign eye3     = n3_side[287:192];
    assign ax_in[0] = n3_side[95:0];
    assign ax_in[1] = uw3;
    assign ax_in[2] = n3_side[191:96];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[a][i] <= $signed(ax_in[a][i]) * $signed(eye3[i]);
                end
                dot_reg[a] <= prod_reg[a][0] + prod_reg[a][1] + prod_reg[a][2];
                sh_reg[a]  <= shift_of(dot_reg[a]);
                ax1_reg[a] <= ax_in[a];
                ax2_reg[a] <= ax1_reg[a];
                ax_reg[a]  <= ax2_reg[a];
            end
        end
    end

    assign out_valid    = dv_reg[2];
    assign right_x      = ax_reg[0][0];
    assign right_y      = ax_reg[0][1];
    assign right_z      = ax_reg[0][2];
    assign right_shift  = sh_reg[0];
    assign upward_x     = ax_reg[1][0];
    assign upward_y     = ax_reg[1][1];
    assign upward_z     = ax_reg[1][2];
    assign upward_shift = sh_reg[1];
    assign back_x       = ax_reg[2][0];
    assign back_y       = ax_reg[2][1];
    assign back_z       = ax_reg[2][2];
    assign back_shift   = sh_reg[2];

    // a zero back axis forces the derived axes to zero; checked on right_x, upward_x and right_shift
    a_zero_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && back_x == 0 && back_y == 0 && back_z == 0
        |-> right_x == 0 && upward_x == 0 && right_shift == 0)
        else $error("zero back axis gave nonzero derived axis");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(right_x) <= 32'sh4000_0000)
                   && ($signed(right_x) >= -32'sh4000_0000)
                   && ($signed(back_z) <= 32'sh4000_0000)
                   && ($signed(back_z) >= -32'sh4000_0000))
        else $error("axis component beyond unit");

    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(dv_reg) && $stable(v1_reg))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// ===== bench/look_at_view_matrix_tb.sv =====
module look_at_view_matrix_tb;

    localparam int PIPE_DEPTH = 224;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 800;

    typedef struct packed {
        logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
    } view_req_t;

    typedef struct packed {
        logic signed [31:0] rx, ry, rz, rs, wx, wy, wz, ws, bx, by, bz, bs;
    } view_frame_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    view_req_t cur;
    logic signed [31:0] right_x, right_y, right_z, right_shift;
    logic signed [31:0] upward_x, upward_y, upward_z, upward_shift;
    logic signed [31:0] back_x, back_y, back_z, back_shift;

    view_req_t   pending_reqs[$];
    view_frame_t frames_due[$];
    int fail_count;
    int cycle_count;
    bit stim_done;
    bit hold_sender;
    bit flood_on;
    bit req_taken;
    int burst_left;
    int gap_left;

    look_at_view_matrix dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .eye_x(cur.ex), .eye_y(cur.ey), .eye_z(cur.ez),
        .target_x(cur.tx), .target_y(cur.ty), .target_z(cur.tz),
        .up_x(cur.ux), .up_y(cur.uy), .up_z(cur.uz),
        .out_valid(out_valid), .out_stall(out_stall),
        .right_x(right_x), .right_y(right_y), .right_z(right_z),
        .right_shift(right_shift),
        .upward_x(upward_x), .upward_y(upward_y), .upward_z(upward_z),
        .upward_shift(upward_shift),
        .back_x(back_x), .back_y(back_y), .back_z(back_z), .back_shift(back_shift)
    );

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n)
            bt >>= 2;
        while (bt != 0)
        begin
            if (n >= res + bt)
            begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic void unit_axis(input logic signed [63:0] v[3],
                                      output logic signed [63:0] u[3]);
        logic [63:0] m[3];
        logic [63:0] mx, sum, len, q;
        int rs, ls;
        rs = 0;
        ls = 0;
        for (int i = 0; i < 3; i++)
            m[i] = abs64(v[i]);
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0)
        begin
            for (int i = 0; i < 3; i++)
                u[i] = 0;
            return;
        end
        while (mx >= (64'd1 << 31))
        begin
            mx >>= 1;
            rs++;
        end
        while (mx < (64'd1 << 30))
        begin
            mx <<= 1;
            ls++;
        end
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (m[i] >> rs) << ls;
            sum += m[i] * m[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 30) + (len >> 1)) / len;
            if (q > (64'd1 << 30))
                q = 64'd1 << 30;
            u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic signed [31:0] eye_offset(input logic signed [63:0] a[3],
                                                      input logic signed [63:0] e[3]);
        logic signed [63:0] d, t;
        logic [63:0] r;
        d = a[0] * e[0] + a[1] * e[1] + a[2] * e[2];
        r = (abs64(d) + (64'd1 << 29)) >> 30;
        t = d < 0 ? $signed(r) : -$signed(r);
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return t[31:0];
    endfunction

    function automatic void cross3(input logic signed [63:0] a[3],
                                   input logic signed [63:0] b[3],
                                   output logic signed [63:0] c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic view_frame_t view_frame_of(view_req_t r);
        logic signed [63:0] eye[3], dv[3], bk[3], rt[3], uw[3], up[3], tmp[3];
        view_frame_t f;
        eye = '{64'(r.ex), 64'(r.ey), 64'(r.ez)};
        up  = '{64'(r.ux), 64'(r.uy), 64'(r.uz)};
        dv  = '{64'(r.ex) - 64'(r.tx), 64'(r.ey) - 64'(r.ty), 64'(r.ez) - 64'(r.tz)};
        unit_axis(dv, bk);
        cross3(up, bk, tmp);
        unit_axis(tmp, rt);
        cross3(bk, rt, tmp);
        unit_axis(tmp, uw);
        f.rx = rt[0][31:0]; f.ry = rt[1][31:0]; f.rz = rt[2][31:0];
        f.rs = eye_offset(rt, eye);
        f.wx = uw[0][31:0]; f.wy = uw[1][31:0]; f.wz = uw[2][31:0];
        f.ws = eye_offset(uw, eye);
        f.bx = bk[0][31:0]; f.by = bk[1][31:0]; f.bz = bk[2][31:0];
        f.bs = eye_offset(bk, eye);
        return f;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", field, got, want);
        fail_count++;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            3: return 32'($signed($urandom_range(0, 40)) - 20) << 16;
            4: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    function automatic view_req_t random_req();
        view_req_t r;
        r = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord(), pick_coord(), pick_coord(), pick_coord()};
        case ($urandom_range(0, 15))
            0: {r.tx, r.ty, r.tz} = {r.ex, r.ey, r.ez};
            1: {r.ux, r.uy, r.uz} = {r.ex - r.tx, r.ey - r.ty, r.ez - r.tz};
            2: {r.ux, r.uy, r.uz} = '0;
            3: {r.ux, r.uy, r.uz} = {32'sd0, 32'sh10000, 32'sd0};
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_req(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
        pending_reqs.push_back({ex, ey, ez, tx, ty, tz, ux, uy, uz});
    endtask

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        stim_done = 0;
        hold_sender = 0;
        flood_on = 0;
        fail_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed corners
        add_req(0, 0, 32'h50000, 0, 0, 0, 0, 32'h10000, 0);
        add_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h80000000, 32'h7fffffff);
        add_req(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h80000000, 32'h80000000, 32'h80000000);
        add_req(32'h30000, 32'h20000, 32'h10000, 32'h30000, 32'h20000, 32'h10000,
                0, 32'h10000, 0);
        add_req(32'h10000, 0, 0, 0, 0, 0, 0, 0, 0);
        add_req(0, 32'h10000, 0, 0, 0, 0, 0, 32'h10000, 0);
        add_req(32'h12345, 32'hffff0000, 32'h7000, 32'h1, 32'h2, 32'h3, 1, 1, 1);
        add_req(1, 0, 0, 0, 0, 0, 0, 1, 0);
        add_req(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 32'h7fffffff, 0);
        add_req(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0,
                32'hffffffff, 32'h1, 32'hffffffff);
        for (int i = 0; i < 4; i++)
            pending_reqs.push_back(random_req());
        while (pending_reqs.size() > 0)
            @(posedge clk);
        // sender waits for the pipeline to drain completely
        hold_sender = 1;
        while (frames_due.size() > 0)
            @(posedge clk);
        hold_sender = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_reqs.push_back(random_req());
        flood_on = 1;
        while (pending_reqs.size() > 0)
            @(posedge clk);
        while (frames_due.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        stim_done = 1;
    end

    // driver: bursts with random gaps
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            cur <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_valid || req_taken)
        begin
            if (hold_sender || pending_reqs.size() == 0)
                in_valid <= 0;
            else if (gap_left > 0)
            begin
                in_valid <= 0;
                gap_left <= gap_left - 1;
            end
            else
            begin
                in_valid <= 1;
                cur <= pending_reqs.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // predict at acceptance
    always @(posedge clk)
    begin
        req_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            frames_due.push_back(view_frame_of(cur));
    end

    // receiver stall pattern, with one long hold-off while requests keep coming
    initial
    begin
        int phase;
        out_stall = 0;
        @(posedge rst_n);
        wait (flood_on);
        repeat (30) @(negedge clk);
        out_stall = 1;
        repeat (600) @(negedge clk);
        out_stall = 0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if ((phase / 200) % 3 == 0)
                out_stall = 0;
            else if ((phase / 200) % 3 == 1)
                out_stall = $urandom_range(0, 3) == 0;
            else
                out_stall = (phase % 7) < 3;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        view_frame_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frames_due.size() == 0)
            begin
                $display("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                w = frames_due.pop_front();
                if (right_x !== w.rx) report_mismatch("right_x", right_x, w.rx);
                if (right_y !== w.ry) report_mismatch("right_y", right_y, w.ry);
                if (right_z !== w.rz) report_mismatch("right_z", right_z, w.rz);
                if (right_shift !== w.rs) report_mismatch("right_shift", right_shift, w.rs);
                if (upward_x !== w.wx) report_mismatch("upward_x", upward_x, w.wx);
                if (upward_y !== w.wy) report_mismatch("upward_y", upward_y, w.wy);
                if (upward_z !== w.wz) report_mismatch("upward_z", upward_z, w.wz);
                if (upward_shift !== w.ws)
                    report_mismatch("upward_shift", upward_shift, w.ws);
                if (back_x !== w.bx) report_mismatch("back_x", back_x, w.bx);
                if (back_y !== w.by) report_mismatch("back_y", back_y, w.by);
                if (back_z !== w.bz) report_mismatch("back_z", back_z, w.bz);
                if (back_shift !== w.bs) report_mismatch("back_shift", back_shift, w.bs);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (stim_done)
            begin
                if (frames_due.size() > 0)
                begin
                    $display("requests left without a result: %0d", frames_due.size());
                    fail_count++;
                end
                if (fail_count == 0)
                    $display("Verification passed");
                else
                    $display("Verification failed");
                $finish;
            end
            else if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout");
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
